// ===== sv/kufef_pkg.sv =====
package kufef_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS    = NODE_BITS + 1;
  localparam int WEIGHT_BITS = 16;
  localparam int COST_BITS   = 26;
  localparam int RANK_BITS   = 4;

  localparam logic [RANK_BITS-1:0] RANK_MAX = '1;
  localparam logic signed [COST_BITS-1:0] COST_MAX = {1'b0, {(COST_BITS-1){1'b1}}};
  localparam logic signed [COST_BITS-1:0] COST_MIN = {1'b1, {(COST_BITS-1){1'b0}}};

  // One entry of the union-find store: rank and parent side by side.
  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    logic [NODE_BITS-1:0] parent;
  } entry_t;

endpackage

// ===== sv/kruskal_union_find_edge_filter.sv =====
// The time from request to result grows with da and db, the link counts from each endpoint
// to its root; an out-of-range edge skips the root search. A new edge is taken only after the
// result of the last one has entered the output register; the store has a single read port.
// A finished result waits in the output register while the next edge is taken.
// Reset: synchronous; a clearing pass over all MAX_NODES (1024) entries sets every node as
// its own root with rank zero, during which no edge is taken. node_count resets to 1024.
module kruskal_union_find_edge_filter (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   node_count_we,
  input  logic [kufef_pkg::CNT_BITS-1:0]         node_count_data,
  input  logic                                   edge_valid,
  output logic                                   edge_stall,
  input  logic [kufef_pkg::NODE_BITS-1:0]        node_a,
  input  logic [kufef_pkg::NODE_BITS-1:0]        node_b,
  input  logic signed [kufef_pkg::WEIGHT_BITS-1:0] weight,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   accepted,
  output logic                                   range_error,
  output logic signed [kufef_pkg::COST_BITS-1:0] cost_total
);
  import kufef_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND_REQ,
    S_FIND_CHK,
    S_COMP_REQ,
    S_COMP_CHK,
    S_UNION,
    S_BUMP,
    S_DONE
  } state_t;

  state_t state;

  entry_t mem [MAX_NODES];
  entry_t mem_rdata;
  entry_t mem_wdata;
  logic   mem_we;
  logic [NODE_BITS-1:0] mem_waddr;
  logic [NODE_BITS-1:0] mem_raddr;

  logic [CNT_BITS-1:0]  node_count;
  logic [NODE_BITS-1:0] clr_idx;
  logic [NODE_BITS-1:0] a_reg;
  logic [NODE_BITS-1:0] b_reg;
  logic signed [WEIGHT_BITS-1:0] w_reg;
  logic [NODE_BITS-1:0] cur;
  logic                 phase_b;
  logic [NODE_BITS-1:0] root_a;
  logic [NODE_BITS-1:0] root_b;
  logic [RANK_BITS-1:0] rank_a;
  logic [RANK_BITS-1:0] rank_b;
  logic                 acc_flag;
  logic                 err_flag;
  logic signed [COST_BITS-1:0] running_cost;

  logic [CNT_BITS-1:0]  lim;
  logic                 out_of_range;
  logic [NODE_BITS-1:0] root_sel;
  logic                 roots_differ;
  logic signed [COST_BITS:0] cost_sum;
  logic signed [COST_BITS-1:0] cost_next;

  assign lim = (node_count > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES) : node_count;
  assign out_of_range = ({1'b0, node_a} >= lim) || ({1'b0, node_b} >= lim);
  assign root_sel = phase_b ? root_b : root_a;
  assign roots_differ = (root_a != root_b);

  assign cost_sum = (COST_BITS+1)'(w_reg) + (COST_BITS+1)'(running_cost);
  always_comb begin
    if (cost_sum[COST_BITS] != cost_sum[COST_BITS-1]) begin
      cost_next = cost_sum[COST_BITS] ? COST_MIN : COST_MAX;
    end else begin
      cost_next = cost_sum[COST_BITS-1:0];
    end
  end

  assign edge_stall = rst || (state != S_IDLE);

  // Store access steering. In path compression, a write and a read in one cycle never meet on one entry:
  // a compression write and the read of the next node on the chain are distinct.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '{rank: mem_rdata.rank, parent: root_sel};
    mem_raddr = cur;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '{rank: '0, parent: clr_idx};
      end
      S_FIND_CHK: begin
        mem_raddr = mem_rdata.parent;
      end
      S_COMP_CHK: begin
        mem_we    = 1'b1;
        mem_raddr = mem_rdata.parent;
      end
      S_UNION: begin
        mem_we = roots_differ;
        if (rank_a > rank_b) begin
          mem_waddr = root_b;
          mem_wdata = '{rank: rank_b, parent: root_a};
        end else begin
          mem_waddr = root_a;
          mem_wdata = '{rank: rank_a, parent: root_b};
        end
      end
      S_BUMP: begin
        mem_we    = roots_differ && (rank_a == rank_b) && (rank_b != RANK_MAX);
        mem_waddr = root_b;
        mem_wdata = '{rank: rank_b + RANK_BITS'(1), parent: root_b};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      node_count   <= CNT_BITS'(MAX_NODES);
      running_cost <= '0;
      result_valid <= 1'b0;
      phase_b      <= 1'b0;
    end else begin
      if (node_count_we) begin
        node_count <= node_count_data;
      end
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + NODE_BITS'(1);
          if (clr_idx == NODE_BITS'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (edge_valid) begin
            a_reg    <= node_a;
            b_reg    <= node_b;
            w_reg    <= weight;
            cur      <= node_a;
            phase_b  <= 1'b0;
            acc_flag <= 1'b0;
            err_flag <= out_of_range;
            state    <= out_of_range ? S_DONE : S_FIND_REQ;
          end
        end
        S_FIND_REQ: begin
          state <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (mem_rdata.parent == cur) begin
            if (phase_b) begin
              root_b <= cur;
              rank_b <= mem_rdata.rank;
              cur    <= b_reg;
            end else begin
              root_a <= cur;
              rank_a <= mem_rdata.rank;
              cur    <= a_reg;
            end
            state <= S_COMP_REQ;
          end else begin
            cur <= mem_rdata.parent;
          end
        end
        S_COMP_REQ: begin
          if (cur != root_sel) begin
            state <= S_COMP_CHK;
          end else if (phase_b) begin
            state <= S_UNION;
          end else begin
            phase_b <= 1'b1;
            cur     <= b_reg;
            state   <= S_FIND_REQ;
          end
        end
        S_COMP_CHK: begin
          if (mem_rdata.parent != root_sel) begin
            cur <= mem_rdata.parent;
          end else if (phase_b) begin
            state <= S_UNION;
          end else begin
            phase_b <= 1'b1;
            cur     <= b_reg;
            state   <= S_FIND_REQ;
          end
        end
        S_UNION: begin
          if (roots_differ) begin
            running_cost <= cost_next;
            acc_flag     <= 1'b1;
          end
          state <= S_BUMP;
        end
        S_BUMP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            accepted     <= acc_flag;
            range_error  <= err_flag;
            cost_total   <= running_cost;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/kufef_check.sv =====
module kufef_check (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     node_count_we,
  input logic [kufef_pkg::CNT_BITS-1:0]           node_count_data,
  input logic                                     edge_valid,
  input logic                                     edge_stall,
  input logic [kufef_pkg::NODE_BITS-1:0]          node_a,
  input logic [kufef_pkg::NODE_BITS-1:0]          node_b,
  input logic signed [kufef_pkg::WEIGHT_BITS-1:0] weight,
  input logic                                     result_valid,
  input logic                                     result_stall,
  input logic                                     accepted,
  input logic                                     range_error,
  input logic signed [kufef_pkg::COST_BITS-1:0]   cost_total
);
  import kufef_pkg::*;

  logic edge_fire;
  logic result_fire;
  logic [1:0] pending;
  logic signed [COST_BITS-1:0] last_cost;

  assign edge_fire   = edge_valid && !edge_stall;
  assign result_fire = result_valid && !result_stall;

  // Requests taken but not yet answered, and the cost last reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      last_cost <= '0;
    end else begin
      pending <= pending + 2'(edge_fire) - 2'(result_fire);
      if (result_fire) begin
        last_cost <= cost_total;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid && edge_stall)
    else $error("result or request path live right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(cost_total))
    else $error("stalled result changed");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd0) |-> !result_valid)
    else $error("result without an outstanding request");

  a_err_not_accepted: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(accepted && range_error))
    else $error("edge both accepted and out of range");

  a_cost_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    result_fire && !accepted |-> cost_total == last_cost)
    else $error("cost moved on a rejected edge");

endmodule

bind kruskal_union_find_edge_filter kufef_check u_kufef_check (.*);
